// ===== src/cfig_pkg.sv =====
// Shared types, register indices and reset values for the machine CSR file.
// Used by cfig_store, cfig_shadow and csr_file_interrupt_gate_unit.
package cfig_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [IDX_W-1:0] TIMECMP_LO_INDEX = IDX_W'(2048);
    localparam logic [IDX_W-1:0] TIMECMP_HI_INDEX = IDX_W'(2049);
    localparam logic [IDX_W-1:0] CPU_RESET_INDEX  = IDX_W'(2050);
    localparam logic [IDX_W-1:0] HW_STATE_INDEX   = IDX_W'(4032);
    localparam logic [IDX_W-1:0] PC_INDEX         = IDX_W'(4033);

    localparam logic [IDX_W-1:0] IDX_MSTATUS  = IDX_W'(12'h300);
    localparam logic [IDX_W-1:0] IDX_MISA     = IDX_W'(12'h301);
    localparam logic [IDX_W-1:0] IDX_MIE      = IDX_W'(12'h304);
    localparam logic [IDX_W-1:0] IDX_CYCLE_LO = IDX_W'(12'hC00);
    localparam logic [IDX_W-1:0] IDX_TIME_LO  = IDX_W'(12'hC01);
    localparam logic [IDX_W-1:0] IDX_RET_LO   = IDX_W'(12'hC02);
    localparam logic [IDX_W-1:0] IDX_CYCLE_HI = IDX_W'(12'hC80);
    localparam logic [IDX_W-1:0] IDX_TIME_HI  = IDX_W'(12'hC81);
    localparam logic [IDX_W-1:0] IDX_RET_HI   = IDX_W'(12'hC82);
    localparam logic [IDX_W-1:0] IDX_HARTID   = IDX_W'(12'hF14);

    localparam logic [31:0] MISA_RESET    = 32'h0080_1100;
    localparam logic [31:0] TIMECMP_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_UPDATE = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] access_address;
        logic [31:0] write_data;
        logic [63:0] wall_time;
        logic [31:0] execute_count;
        logic [63:0] retired_count;
        logic [31:0] program_counter;
        logic        uart_irq;
        logic        key_irq;
    } item_t;

    typedef struct packed {
        logic [1:0] irq_lines;
        logic       soft_irq;
        logic       reset_latched;
    } irq_status_t;

    function automatic logic [IDX_W-1:0] slot_of(input logic [31:0] addr);
        return addr[IDX_W+1:2];
    endfunction

    function automatic logic [31:0] store_reset_value(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx == TIMECMP_LO_INDEX || idx == TIMECMP_HI_INDEX)
            v = TIMECMP_RESET;
        else if (idx == IDX_MISA)
            v = MISA_RESET;
        return v;
    endfunction

endpackage

// ===== src/cfig_store.sv =====
// Register store: 4096 x 32 synchronous memory with a registered read port
// and a pass after reset that writes the reset image. Depends on cfig_pkg.
module cfig_store
    import cfig_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] index,
    input  logic [31:0]      wr_data,
    output logic [31:0]      rd_data,
    output logic             busy
);

    logic [31:0]      mem [STORE_DEPTH];
    logic [31:0]      rd_data_reg;
    logic             clear_reg, clear_next;
    logic [IDX_W-1:0] clear_idx_reg, clear_idx_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wd;

    always_comb
    begin
        clear_next     = clear_reg;
        clear_idx_next = clear_idx_reg;
        if (clear_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == '1)
                clear_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_idx_reg <= '0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    // sweep the reset image in while busy, item writes otherwise
    assign mem_we = clear_reg || wr_en;
    assign mem_wa = clear_reg ? clear_idx_reg : index;
    assign mem_wd = clear_reg ? store_reset_value(clear_idx_reg) : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_data_reg <= mem[index];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clear_reg;

endmodule

// ===== src/cfig_shadow.sv =====
// Shadow registers, counters and interrupt evaluation beside the store.
// Also selects the live word for special read indices. Depends on cfig_pkg.
module cfig_shadow
    import cfig_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr,
    input  logic [31:0] cfg_word,
    input  logic        accept,
    input  item_t       item,
    output logic        live_hit,
    output logic [31:0] live_word,
    output irq_status_t status
);

    logic [31:0]      hart_id_reg;
    logic [63:0]      timer_compare_reg, timer_compare_next;
    logic [2:0]       enable_reg, enable_next;
    logic             global_en_reg, global_en_next;
    logic             reset_req_reg, reset_req_next;
    logic             reset_latched_reg, reset_latched_next;
    logic [31:0]      cycle_reg, cycle_next;
    logic [63:0]      wall_reg, wall_next;
    logic [1:0]       pending_reg, pending_next;
    logic [1:0]       irq_lines_reg, irq_lines_next;
    logic             soft_irq_reg, soft_irq_next;
    logic [IDX_W-1:0] idx;
    logic             timer_due;

    assign idx       = slot_of(item.access_address);
    assign timer_due = wall_reg >= timer_compare_reg;

    always_comb
    begin
        timer_compare_next = timer_compare_reg;
        enable_next        = enable_reg;
        global_en_next     = global_en_reg;
        reset_req_next     = reset_req_reg;
        reset_latched_next = reset_latched_reg;
        cycle_next         = cycle_reg;
        wall_next          = wall_reg;
        pending_next       = pending_reg;
        irq_lines_next     = irq_lines_reg;
        soft_irq_next      = soft_irq_reg;
        if (accept)
        begin
            unique case (item.kind)
                REQ_WRITE:
                begin
                    priority if (idx == CPU_RESET_INDEX)
                        reset_req_next = item.write_data[0];
                    else if (idx == TIMECMP_LO_INDEX)
                        timer_compare_next[31:0] = item.write_data;
                    else if (idx == TIMECMP_HI_INDEX)
                        timer_compare_next[63:32] = item.write_data;
                    else if (idx == IDX_MIE)
                        enable_next = {item.write_data[11], item.write_data[7],
                                       item.write_data[3]};
                    else if (idx == IDX_MSTATUS)
                        global_en_next = item.write_data[3];
                    else
                        // other indices only land in the store
                        ;
                end
                REQ_TICK:
                begin
                    if (reset_req_reg)
                    begin
                        reset_req_next     = 1'b0;
                        reset_latched_next = 1'b1;
                    end
                    pending_next      = {item.uart_irq, item.key_irq};
                    soft_irq_next     = enable_reg[0] && global_en_reg;
                    irq_lines_next[1] = enable_reg[1] && global_en_reg && timer_due;
                    irq_lines_next[0] = enable_reg[2] && global_en_reg
                                        && (item.uart_irq || item.key_irq);
                end
                REQ_UPDATE:
                begin
                    wall_next  = item.wall_time;
                    cycle_next = item.execute_count;
                end
                REQ_READ: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hart_id_reg       <= '0;
            timer_compare_reg <= '1;
            enable_reg        <= '0;
            global_en_reg     <= 1'b0;
            reset_req_reg     <= 1'b0;
            reset_latched_reg <= 1'b0;
            cycle_reg         <= '0;
            wall_reg          <= '0;
            pending_reg       <= '0;
            irq_lines_reg     <= '0;
            soft_irq_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                hart_id_reg <= cfg_word;
            timer_compare_reg <= timer_compare_next;
            enable_reg        <= enable_next;
            global_en_reg     <= global_en_next;
            reset_req_reg     <= reset_req_next;
            reset_latched_reg <= reset_latched_next;
            cycle_reg         <= cycle_next;
            wall_reg          <= wall_next;
            pending_reg       <= pending_next;
            irq_lines_reg     <= irq_lines_next;
            soft_irq_reg      <= soft_irq_next;
        end
    end

    // live indices shadow the store; first match wins
    always_comb
    begin
        live_hit  = 1'b1;
        live_word = '0;
        priority if (idx == IDX_HARTID)
            live_word = hart_id_reg;
        else if (idx == IDX_RET_HI)
            live_word = item.retired_count[63:32];
        else if (idx == IDX_TIME_HI)
            live_word = wall_reg[63:32];
        else if (idx == IDX_CYCLE_HI)
            live_word = '0;
        else if (idx == IDX_RET_LO)
            live_word = item.retired_count[31:0];
        else if (idx == IDX_TIME_LO)
            live_word = wall_reg[31:0];
        else if (idx == IDX_CYCLE_LO)
            live_word = cycle_reg;
        else if (idx == HW_STATE_INDEX)
            live_word = {29'd0, pending_reg, 1'b0};
        else if (idx == PC_INDEX)
            live_word = item.program_counter;
        else
            live_hit = 1'b0;
    end

    assign status.irq_lines     = irq_lines_reg;
    assign status.soft_irq      = soft_irq_reg;
    assign status.reset_latched = reset_latched_reg;

endmodule

// ===== src/csr_file_interrupt_gate_unit.sv =====
// Top level of the machine CSR file with interrupt gate: stream ports,
// access stage and output register. Depends on cfig_pkg, cfig_store, cfig_shadow.
//
//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | s_tdata (258 bits in 264), s_tuser req_type
//  m       | out       | m_tvalid/m_tready  | m_tdata (36 bits in 40)
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data hart_id
//
// One item per cycle while the output is not stalled; each result passes the access
// stage and then the output register before it is offered.
// Read data come from the registered store read port, lined up with the access stage.
// After reset the store is swept with its reset image over all 4096 indices;
// s_tready stays low until the sweep ends. cfg writes are taken at any time.
// A stalled output holds the access stage, which then holds s_tready low.
module csr_file_interrupt_gate_unit
    import cfig_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] access_address, [63:32] write_data, [127:64] wall_time,
    // [159:128] execute_count, [223:160] retired_count, [255:224] program_counter,
    // [256] uart_irq, [257] key_irq, [263:258] zero
    input  logic [263:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] read_data, [33:32] interrupt_lines, [34] software_irq,
    // [35] reset_pending, [39:36] zero
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    item_t       item;
    logic        accept;
    logic        busy;
    logic [31:0] mem_rd;
    logic        live_hit;
    logic [31:0] live_word;
    irq_status_t status;

    logic        p1_valid_reg, p1_valid_next;
    logic        p1_read_reg;
    logic        p1_live_reg;
    logic [31:0] p1_live_word_reg;
    logic        p1_adv;
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg;
    logic [31:0] read_word;

    assign item.kind            = req_kind_t'(s_tuser);
    assign item.access_address  = s_tdata[31:0];
    assign item.write_data      = s_tdata[63:32];
    assign item.wall_time       = s_tdata[127:64];
    assign item.execute_count   = s_tdata[159:128];
    assign item.retired_count   = s_tdata[223:160];
    assign item.program_counter = s_tdata[255:224];
    assign item.uart_irq        = s_tdata[256];
    assign item.key_irq         = s_tdata[257];

    assign cfg_ready = 1'b1;
    assign p1_adv    = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !busy && (!p1_valid_reg || p1_adv);
    assign accept    = s_tvalid && s_tready;

    cfig_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && item.kind == REQ_READ),
        .wr_en   (accept && item.kind == REQ_WRITE),
        .index   (slot_of(item.access_address)),
        .wr_data (item.write_data),
        .rd_data (mem_rd),
        .busy    (busy)
    );

    cfig_shadow u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_word  (cfg_data),
        .accept    (accept),
        .item      (item),
        .live_hit  (live_hit),
        .live_word (live_word),
        .status    (status)
    );

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
            p1_valid_next = 1'b1;
        else if (p1_adv)
            p1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (p1_adv)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_read_reg      <= item.kind == REQ_READ;
            p1_live_reg      <= live_hit;
            p1_live_word_reg <= live_word;
        end
        if (p1_adv)
            m_data_reg <= {4'd0, status.reset_latched, status.soft_irq,
                           status.irq_lines, read_word};
    end

    // status is sampled after the item has taken effect: nothing else enters meanwhile
    assign read_word = !p1_read_reg ? '0 : (p1_live_reg ? p1_live_word_reg : mem_rd);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_no_transfer_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("input transfer during store sweep");

    a_stage_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && !p1_adv |-> !s_tready)
        else $error("access stage overwritten while held");

    a_reset_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        status.reset_latched |=> status.reset_latched)
        else $error("latched reset request cleared");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        p1_adv && !p1_read_reg |=> m_tdata[31:0] == '0)
        else $error("non-read result carries data");

endmodule
